>>> hdl/priority_message_queue_top_defines.svh
// assertion helpers for the priority queue checker
`ifndef PRIORITY_MESSAGE_QUEUE_TOP_DEFINES_SVH
`define PRIORITY_MESSAGE_QUEUE_TOP_DEFINES_SVH

`define PMQ_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("pmq check failed");

`define PMQ_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("pmq check failed");

`endif

>>> hdl/pmq_pkg.sv
package pmq_pkg;
  localparam int QueueDepth   = 16;
  localparam int MessageBytes = 256;
  localparam int TopPriority  = 10;
  localparam int SlotWords    = (MessageBytes + 7) / 8;
  localparam int SlotW        = $clog2(QueueDepth);
  localparam int WordW        = $clog2(SlotWords);
  localparam int AddrW        = SlotW + WordW;
  localparam int LenW         = $clog2(MessageBytes + 1);
  localparam int CountW       = $clog2(QueueDepth + 1);

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  localparam logic OpWrite = 1'b0;
  localparam logic OpRead  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [63:0] write_data;
    logic [3:0]  write_bytes;
    logic        write_last;
    logic [3:0]  priority_req;
    logic [8:0]  read_limit;
  } req_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic [3:0]  byte_count;
    logic        last;
    logic [1:0]  status;
    logic [8:0]  message_length;
    logic [4:0]  queue_count;
  } rsp_t;
endpackage

>>> hdl/pmq_if.sv
interface pmq_req_if;
  logic valid;
  logic ready;
  pmq_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pmq_rsp_if;
  logic valid;
  logic ready;
  pmq_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pmq_cfg_if;
  logic valid;
  logic ready;
  logic [4:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/priority_message_queue_top.sv
// Priority message queue.
// Channels: req (write chunk or read request), rsp (result words), cfg
// (queue_limit, ready always high). valid/ready handshakes. cfg is to be
// written only while idle; the block itself does not enforce this.
// A write chunk of n bytes (n capped at 8) is merged into the message word
// one byte at a time (merge, then store). On the last chunk the insert walk
// compares the new priority against the order list one entry per cycle, then
// shifts the list one entry per cycle.
// A read pops the head: the list shifts one entry per cycle. Then the payload
// memory streams the words (address, data, handoff) while the receiver keeps up.
// A read with limit 0 gives no result. Empty reads and full writes give one
// status result in the cycle after accept.
// Results sit in an output register. A stalled receiver holds the block in
// its present state and nothing is lost. ready returns in the cycle after the
// last result is taken.
// Reset: queue empty, all slots free, limit 10; memories are not cleared.
module priority_message_queue_top (
  input logic clk,
  input logic rst,
  pmq_req_if.sink   req,
  pmq_rsp_if.source rsp,
  pmq_cfg_if.sink   cfg
);
  import pmq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_WADDR, S_MERGE, S_WSTORE, S_WOUT, S_FIND, S_SHIFT, S_POP, S_RADDR,
    S_RDATA, S_ROUT
  } state_t;

  state_t state;
  logic [63:0] mem [QueueDepth*SlotWords];
  logic [63:0] mem_q;
  logic [AddrW-1:0] mem_addr;
  logic mem_we;
  logic [LenW-1:0] slot_len [QueueDepth];
  logic [3:0] slot_pri [QueueDepth];
  logic [SlotW-1:0] order [QueueDepth];
  logic [CountW-1:0] count;
  logic [QueueDepth-1:0] free_map;
  logic [SlotW-1:0] stg_slot;
  logic [LenW-1:0] stg_len;
  logic stg_open, stg_drop;
  logic [4:0] limit;
  req_t r;
  logic [63:0] word;
  logic [3:0] bidx, bcnt;
  logic [CountW-1:0] pos;
  logic [SlotW-1:0] rslot;
  logic [LenW-1:0] rlen, rdone;
  rsp_t out;
  logic out_valid;
  logic [SlotW-1:0] first_free;
  logic any_free;

  function automatic rsp_t make_rsp(input logic [63:0] d, input logic [3:0] n,
                                    input logic lst, input logic [1:0] st,
                                    input logic [LenW-1:0] len,
                                    input logic [CountW-1:0] qc);
    rsp_t v;
    v.read_data = d;
    v.byte_count = n;
    v.last = lst;
    v.status = st;
    v.message_length = len;
    v.queue_count = qc;
    return v;
  endfunction

  always_comb begin
    first_free = '0;
    any_free = 1'b0;
    for (int i = QueueDepth - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        first_free = SlotW'(i);
        any_free = 1'b1;
      end
    end
  end

  assign req.ready = (state == S_IDLE) && !out_valid;
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.data = out;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= word;
    mem_q <= mem[mem_addr];
  end

  assign mem_we = (state == S_WSTORE);
  always_comb begin
    if (state == S_WSTORE)
      mem_addr = {stg_slot, WordW'((stg_len - LenW'(1)) >> 3)};
    else if (state == S_MERGE || state == S_WADDR)
      mem_addr = {stg_slot, WordW'(stg_len >> 3)};
    else
      mem_addr = {rslot, WordW'(rdone >> 3)};
  end

  logic [LenW-1:0] remain;
  logic [3:0] wcnt;
  assign remain = rlen - rdone;
  assign wcnt = (remain > LenW'(8)) ? 4'd8 : remain[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      free_map <= '1;
      stg_slot <= '0;
      stg_len <= '0;
      stg_open <= 1'b0;
      stg_drop <= 1'b0;
      limit <= 5'd10;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) limit <= cfg.data;
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            r <= req.data;
            if (req.data.operation == OpWrite) begin
              if (stg_drop || (!stg_open && (count >= CountW'(limit) || !any_free))) begin
                stg_drop <= !req.data.write_last;
                out <= make_rsp('0, '0, 1'b1, StatusFull, '0, count);
                out_valid <= 1'b1;
              end else begin
                if (!stg_open) begin
                  stg_open <= 1'b1;
                  stg_slot <= first_free;
                  free_map[first_free] <= 1'b0;
                  stg_len <= '0;
                  slot_pri[first_free] <= (req.data.priority_req > 4'(TopPriority))
                    ? 4'(TopPriority) : req.data.priority_req;
                end
                bidx <= '0;
                bcnt <= (req.data.write_bytes > 4'd8) ? 4'd8 : req.data.write_bytes;
                state <= S_WADDR;
              end
            end else if (req.data.read_limit != '0) begin
              if (count == '0) begin
                out <= make_rsp('0, '0, 1'b1, StatusEmpty, '0, count);
                out_valid <= 1'b1;
              end else begin
                rslot <= order[0];
                rlen <= (slot_len[order[0]] > LenW'(req.data.read_limit))
                  ? LenW'(req.data.read_limit) : slot_len[order[0]];
                rdone <= '0;
                pos <= '0;
                state <= S_POP;
              end
            end
          end
        end
        // address of the partial word goes out, data is back in S_MERGE
        S_WADDR: state <= S_MERGE;
        S_MERGE: begin
          // one byte per pass, read-modify the current word
          if (bidx == bcnt || stg_len >= LenW'(MessageBytes)) begin
            state <= S_WOUT;
          end else begin
            word <= ((bidx == '0) ? mem_q : word)
                    & ~(64'hFF << {stg_len[2:0], 3'b0})
                    | (64'(r.write_data[{bidx[2:0], 3'b0} +: 8]) << {stg_len[2:0], 3'b0});
            stg_len <= stg_len + LenW'(1);
            bidx <= bidx + 4'd1;
            state <= S_WSTORE;
          end
        end
        S_WSTORE: state <= S_MERGE;
        S_WOUT: begin
          if (r.write_last) begin
            stg_open <= 1'b0;
            slot_len[stg_slot] <= stg_len;
            pos <= '0;
            state <= S_FIND;
          end else begin
            out <= make_rsp('0, '0, 1'b1, StatusOk, stg_len, count);
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_FIND: begin
          if (pos < count && slot_pri[order[pos[SlotW-1:0]]] <= slot_pri[stg_slot])
            pos <= pos + CountW'(1);
          else begin
            rdone <= LenW'(count);
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          // rdone holds the shift index here
          if (rdone[CountW-1:0] > pos) begin
            order[rdone[SlotW-1:0]] <= order[rdone[SlotW-1:0] - SlotW'(1)];
            rdone <= rdone - LenW'(1);
          end else begin
            order[pos[SlotW-1:0]] <= stg_slot;
            count <= count + CountW'(1);
            out <= make_rsp('0, '0, 1'b1, StatusOk, stg_len, count + CountW'(1));
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_POP: begin
          if (pos + CountW'(1) < count) begin
            order[pos[SlotW-1:0]] <= order[pos[SlotW-1:0] + SlotW'(1)];
            pos <= pos + CountW'(1);
          end else begin
            count <= count - CountW'(1);
            free_map[rslot] <= 1'b1;
            if (rlen == '0) begin
              out <= make_rsp('0, '0, 1'b1, StatusOk, '0, count - CountW'(1));
              out_valid <= 1'b1;
              state <= S_IDLE;
            end else state <= S_RADDR;
          end
        end
        S_RADDR: if (!out_valid) state <= S_RDATA;
        S_RDATA: begin
          out <= make_rsp((wcnt == 4'd8) ? mem_q
                            : mem_q & ((64'd1 << {wcnt[2:0], 3'b0}) - 64'd1),
                          wcnt, (remain <= LenW'(8)), StatusOk, rlen, count);
          out_valid <= 1'b1;
          rdone <= rdone + LenW'(wcnt);
          state <= (remain <= LenW'(8)) ? S_IDLE : S_RADDR;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/pmq_checker.sv
module pmq_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic [3:0] byte_count,
  input logic [1:0] status,
  input logic last
);
  import pmq_pkg::*;
  `include "priority_message_queue_top_defines.svh"
  `PMQ_ASSERT_NEXT(a_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  `PMQ_ASSERT_IMPL(a_bytes, clk, rst, rsp_valid, byte_count <= 4'd8)
  `PMQ_ASSERT_IMPL(a_err_last, clk, rst, rsp_valid && status != StatusOk, last)
  `PMQ_ASSERT_IMPL(a_busy, clk, rst, rsp_valid, !req_ready)
endmodule

bind priority_message_queue_top pmq_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .byte_count(rsp.data.byte_count), .status(rsp.data.status),
  .last(rsp.data.last)
);
